FILE: rtl/core/rgb_run_length_dither_expander_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB run-length dither expander
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_RUN_LENGTH_DITHER_EXPANDER_ASSERT_SVH
`define RGB_RUN_LENGTH_DITHER_EXPANDER_ASSERT_SVH

// Same-cycle implication.
`define RLDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rlde_pkg.sv
// ----------------------------------------------------------------------------
// rlde_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rlde_pkg;

    localparam int POSITION_WIDTH  = 16;
    localparam int WRAP_WIDTH      = POSITION_WIDTH + 1;
    localparam int DIV_WIDTH       = 2 * POSITION_WIDTH;
    localparam int MOD_CNT_WIDTH   = $clog2(POSITION_WIDTH);
    localparam int CFG_WIDTH       = 16;
    localparam int CMP_WIDTH       = CFG_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int BYTE_WIDTH      = 8;
    localparam int ADDR_WIDTH      = 16;
    localparam int COLOUR_WIDTH    = 5;
    localparam int COUNT_WIDTH     = 3;
    localparam int CHANNEL_WIDTH   = 2;
    localparam int GROUP_WIDTH     = 2;
    localparam int LFSR_WIDTH      = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BUFFER_SIZE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RED_START   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GREEN_START = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLUE_START  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DITHER_SEED = 3'd4;

    localparam logic [CHANNEL_WIDTH-1:0] CH_GREEN = 2'd0;
    localparam logic [CHANNEL_WIDTH-1:0] CH_RED   = 2'd1;
    localparam logic [CHANNEL_WIDTH-1:0] CH_BLUE  = 2'd2;

    localparam logic [GROUP_WIDTH-1:0] GROUP_FIRST = 2'd0;
    localparam logic [GROUP_WIDTH-1:0] GROUP_LAST  = 2'd2;

    localparam logic [LFSR_WIDTH-1:0] LFSR_TAPS    = 16'hB400;
    localparam logic [LFSR_WIDTH-1:0] LFSR_DEFAULT = 16'hACE1;

    localparam logic [CFG_WIDTH-1:0] BUFFER_SIZE_RESET = 16'd3;
    localparam logic [CFG_WIDTH-1:0] RED_START_RESET   = 16'd0;
    localparam logic [CFG_WIDTH-1:0] GREEN_START_RESET = 16'd1;
    localparam logic [CFG_WIDTH-1:0] BLUE_START_RESET  = 16'd2;
    localparam logic [CFG_WIDTH-1:0] SEED_RESET        = 16'd44257;

    // Controller to datapath
    typedef struct packed {
        logic restart;     // load start positions and seed
        logic hold;        // store a byte of the group
        logic hold_sel;    // 0 first byte, 1 second byte
        logic load_group;  // unpack the full group
        logic step;        // advance LFSR, open a round
        logic emit;        // load the output register with one write
        logic mod_step;    // one step of the position remainder loop
    } rlde_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic grp_any;         // completed group has a nonzero count
        logic mask_zero;       // no channel left in this round
        logic mask_rest_zero;  // no channel left after the selected one
        logic cnt_zero;        // all counts used up
        logic need_mod;        // next position needs the remainder loop
        logic last_emit;       // selected write is the final one
        logic out_free;        // output register can take a write
        logic mod_done;        // remainder loop on its final step
    } rlde_sts_t;

endpackage

FILE: rtl/core/rlde_datapath.sv
// ----------------------------------------------------------------------------
// rlde_datapath
// Config registers, positions, counts, dither LFSR, remainder unit and
// output register.
// ----------------------------------------------------------------------------
module rlde_datapath
    import rlde_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rlde_cmd_t                  cmd,
    output rlde_sts_t                  sts,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic [BYTE_WIDTH-1:0]      data_byte,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [ADDR_WIDTH-1:0]      write_address,
    output logic [BYTE_WIDTH-1:0]      write_value,
    output logic [CHANNEL_WIDTH-1:0]   channel,
    output logic                       last_write
);

    function automatic logic [LFSR_WIDTH-1:0] lfsr_next(input logic [LFSR_WIDTH-1:0] v);
        logic [LFSR_WIDTH-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    // (v mod 15) - 7: nibble sum since 16 mod 15 is 1
    function automatic logic signed [3:0] dither_amount(input logic [LFSR_WIDTH-1:0] v);
        logic [5:0] n;
        logic [4:0] f;
        logic signed [4:0] a;
        n = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        f = 5'(n[5:4]) + 5'(n[3:0]);
        if (f >= 5'd15)
        begin
            f = f - 5'd15;
        end
        a = signed'(f) - 5'sd7;
        return a[3:0];
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] dither_apply(
        input logic [COLOUR_WIDTH-1:0] colour,
        input logic signed [3:0]       amount
    );
        logic signed [9:0] s;
        s = signed'({2'b00, colour, 3'b000}) + signed'({{6{amount[3]}}, amount});
        if (colour == '0)
        begin
            return '0;
        end
        else if (s < 10'sd0)
        begin
            return '0;
        end
        else if (s > 10'sd255)
        begin
            return 8'hFF;
        end
        return s[7:0];
    endfunction

    function automatic logic [POSITION_WIDTH-1:0] load_start(
        input logic [CFG_WIDTH-1:0] start,
        input logic [CMP_WIDTH-1:0] wrap_cmp
    );
        if ({1'b0, start} >= wrap_cmp)
        begin
            return '0;
        end
        return start[POSITION_WIDTH-1:0];
    endfunction

    logic [CFG_WIDTH-1:0]          buffer_size_reg;
    logic [CFG_WIDTH-1:0]          red_start_reg;
    logic [CFG_WIDTH-1:0]          green_start_reg;
    logic [CFG_WIDTH-1:0]          blue_start_reg;
    logic [CFG_WIDTH-1:0]          seed_reg;
    logic [BYTE_WIDTH-1:0]         held0_reg;
    logic [BYTE_WIDTH-1:0]         held1_reg;
    logic [POSITION_WIDTH-1:0]     pos_reg [3];
    logic [COUNT_WIDTH-1:0]        cnt_reg [3];
    logic [COLOUR_WIDTH-1:0]       val_reg [3];
    logic [2:0]                    mask_reg;
    logic [LFSR_WIDTH-1:0]         lfsr_reg;
    logic signed [3:0]             amount_reg;
    logic [WRAP_WIDTH-1:0]         rem_reg;
    logic [DIV_WIDTH-1:0]          div_reg;
    logic [MOD_CNT_WIDTH-1:0]      mod_cnt_reg;
    logic [CHANNEL_WIDTH-1:0]      mod_ch_reg;
    logic                          out_valid_reg;
    logic [ADDR_WIDTH-1:0]         addr_reg;
    logic [BYTE_WIDTH-1:0]         value_reg;
    logic [CHANNEL_WIDTH-1:0]      channel_reg;
    logic                          last_reg;

    logic [CMP_WIDTH-1:0]          wrap_cmp;
    logic [WRAP_WIDTH-1:0]         wrap;
    logic [CHANNEL_WIDTH-1:0]      sel_ch;
    logic [2:0]                    sel_hot;
    logic [2:0]                    cnt_nz;
    logic [POSITION_WIDTH-1:0]     sel_pos;
    logic [COUNT_WIDTH-1:0]        sel_cnt;
    logic [WRAP_WIDTH-1:0]         pos_sum;
    logic [WRAP_WIDTH-1:0]         pos_diff;
    logic [POSITION_WIDTH-1:0]     fast_pos;
    logic                          need_mod;
    logic [LFSR_WIDTH-1:0]         lfsr_next_val;
    logic                          trial_ok;
    logic [WRAP_WIDTH-1:0]         rem_next;

    // Effective wrap size: clamp to [3, 2^POSITION_WIDTH]
    always_comb
    begin
        wrap_cmp = {1'b0, buffer_size_reg};
        if (wrap_cmp < CMP_WIDTH'(3))
        begin
            wrap_cmp = CMP_WIDTH'(3);
        end
        else if (wrap_cmp > (CMP_WIDTH'(1) << POSITION_WIDTH))
        begin
            wrap_cmp = CMP_WIDTH'(1) << POSITION_WIDTH;
        end
    end
    assign wrap = wrap_cmp[WRAP_WIDTH-1:0];

    // Round order: green, red, blue
    always_comb
    begin
        if (mask_reg[CH_GREEN])
        begin
            sel_ch = CH_GREEN;
        end
        else if (mask_reg[CH_RED])
        begin
            sel_ch = CH_RED;
        end
        else
        begin
            sel_ch = CH_BLUE;
        end
    end

    assign sel_hot = 3'b001 << sel_ch;
    assign sel_pos = pos_reg[sel_ch];
    assign sel_cnt = cnt_reg[sel_ch];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cnt_nz[i] = (cnt_reg[i] != '0);
        end
    end

    // Next position: one or two compares, else hand off to the remainder loop
    assign pos_sum  = {1'b0, sel_pos} + WRAP_WIDTH'(3);
    assign pos_diff = pos_sum - wrap;

    always_comb
    begin
        need_mod = 1'b0;
        if (pos_sum < wrap)
        begin
            fast_pos = pos_sum[POSITION_WIDTH-1:0];
        end
        else
        begin
            fast_pos = pos_diff[POSITION_WIDTH-1:0];
            need_mod = (pos_diff >= wrap);
        end
    end

    assign lfsr_next_val = lfsr_next(lfsr_reg);

    // Restoring remainder, one shifted divisor per cycle
    assign trial_ok = ({{(DIV_WIDTH-WRAP_WIDTH){1'b0}}, rem_reg} >= div_reg);
    assign rem_next = trial_ok ? (rem_reg - div_reg[WRAP_WIDTH-1:0]) : rem_reg;

    assign sts.grp_any        = (held0_reg[2:0] != '0) || (held1_reg[2:0] != '0)
                              || (data_byte[2:0] != '0);
    assign sts.mask_zero      = (mask_reg == '0);
    assign sts.mask_rest_zero = ((mask_reg & ~sel_hot) == '0);
    assign sts.cnt_zero       = (cnt_nz == '0);
    assign sts.need_mod       = need_mod;
    assign sts.last_emit      = ((cnt_nz & ~sel_hot) == '0) && (sel_cnt == COUNT_WIDTH'(1));
    assign sts.out_free       = !out_valid_reg || out_ready;
    assign sts.mod_done       = (mod_cnt_reg == '0);

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
            red_start_reg   <= RED_START_RESET;
            green_start_reg <= GREEN_START_RESET;
            blue_start_reg  <= BLUE_START_RESET;
            seed_reg        <= SEED_RESET;
            pos_reg[CH_RED]   <= POSITION_WIDTH'(0);
            pos_reg[CH_GREEN] <= POSITION_WIDTH'(1);
            pos_reg[CH_BLUE]  <= POSITION_WIDTH'(2);
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i] <= '0;
            end
            mask_reg      <= '0;
            lfsr_reg      <= LFSR_DEFAULT;
            mod_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BUFFER_SIZE: buffer_size_reg <= cfg_data;
                    CFG_RED_START:   red_start_reg   <= cfg_data;
                    CFG_GREEN_START: green_start_reg <= cfg_data;
                    CFG_BLUE_START:  blue_start_reg  <= cfg_data;
                    CFG_DITHER_SEED: seed_reg        <= cfg_data;
                    default:         ;
                endcase
            end

            if (cmd.restart)
            begin
                pos_reg[CH_RED]   <= load_start(red_start_reg, wrap_cmp);
                pos_reg[CH_GREEN] <= load_start(green_start_reg, wrap_cmp);
                pos_reg[CH_BLUE]  <= load_start(blue_start_reg, wrap_cmp);
                lfsr_reg          <= (seed_reg == '0) ? LFSR_DEFAULT : seed_reg;
            end

            if (cmd.load_group)
            begin
                cnt_reg[CH_RED]   <= held0_reg[2:0];
                cnt_reg[CH_GREEN] <= held1_reg[2:0];
                cnt_reg[CH_BLUE]  <= data_byte[2:0];
            end

            if (cmd.step)
            begin
                lfsr_reg <= lfsr_next_val;
                mask_reg <= cnt_nz;
            end

            if (cmd.emit)
            begin
                cnt_reg[sel_ch]  <= sel_cnt - COUNT_WIDTH'(1);
                mask_reg[sel_ch] <= 1'b0;
                if (!need_mod)
                begin
                    pos_reg[sel_ch] <= fast_pos;
                end
                mod_cnt_reg <= MOD_CNT_WIDTH'(POSITION_WIDTH - 1);
            end

            if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg - MOD_CNT_WIDTH'(1);
                if (mod_cnt_reg == '0)
                begin
                    pos_reg[mod_ch_reg] <= rem_next[POSITION_WIDTH-1:0];
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.hold && !cmd.hold_sel)
        begin
            held0_reg <= data_byte;
        end
        if (cmd.hold && cmd.hold_sel)
        begin
            held1_reg <= data_byte;
        end
        if (cmd.load_group)
        begin
            val_reg[CH_RED]   <= held0_reg[7:3];
            val_reg[CH_GREEN] <= held1_reg[7:3];
            val_reg[CH_BLUE]  <= data_byte[7:3];
        end
        if (cmd.step)
        begin
            amount_reg <= dither_amount(lfsr_next_val);
        end
        if (cmd.emit)
        begin
            addr_reg    <= ADDR_WIDTH'(sel_pos);
            value_reg   <= dither_apply(val_reg[sel_ch], amount_reg);
            channel_reg <= sel_ch;
            last_reg    <= sts.last_emit;
            rem_reg     <= pos_sum;
            div_reg     <= DIV_WIDTH'(wrap) << (POSITION_WIDTH - 1);
            mod_ch_reg  <= sel_ch;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_next;
            div_reg <= div_reg >> 1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = addr_reg;
    assign write_value   = value_reg;
    assign channel       = channel_reg;
    assign last_write    = last_reg;

endmodule

FILE: rtl/core/rlde_ctrl.sv
// ----------------------------------------------------------------------------
// rlde_ctrl
// Group counter and round sequencer for the expander.
// ----------------------------------------------------------------------------
`include "rgb_run_length_dither_expander_assert.svh"

module rlde_ctrl
    import rlde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      mode,
    input  rlde_sts_t sts,
    output rlde_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_MOD  = 4'b1000
    } rlde_state_t;

    rlde_state_t            state_reg;
    rlde_state_t            state_next;
    logic [GROUP_WIDTH-1:0] group_reg;
    logic [GROUP_WIDTH-1:0] group_next;
    logic                   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        group_next = group_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        cmd.restart = 1'b1;
                        group_next  = GROUP_FIRST;
                    end
                    else if (group_reg != GROUP_LAST)
                    begin
                        cmd.hold     = 1'b1;
                        cmd.hold_sel = (group_reg != GROUP_FIRST);
                        group_next   = group_reg + GROUP_WIDTH'(1);
                    end
                    else
                    begin
                        cmd.load_group = 1'b1;
                        group_next     = GROUP_FIRST;
                        if (sts.grp_any)
                        begin
                            state_next = ST_STEP;
                        end
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.mask_zero)
                begin
                    state_next = sts.cnt_zero ? ST_IDLE : ST_STEP;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.need_mod)
                    begin
                        state_next = ST_MOD;
                    end
                    else if (sts.last_emit)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (sts.mask_rest_zero)
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            group_reg <= GROUP_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            group_reg <= group_next;
        end
    end

    `RLDE_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free, "write issued into a full output register")
    `RLDE_ASSERT_NOW(a_group_range, 1'b1, group_reg <= GROUP_LAST, "group counter out of range")
    `RLDE_ASSERT_NEXT(a_step_then_emit, state_reg == ST_STEP, state_reg == ST_EMIT, "round opened without writes")
    `RLDE_ASSERT_NEXT(a_mod_holds, state_reg == ST_MOD && !sts.mod_done, state_reg == ST_MOD, "remainder loop left early")

endmodule

FILE: rtl/core/rgb_run_length_dither_expander.sv
// A restart or the first two bytes of a group leave the sequencer in idle.
// A completed group steps the dither LFSR once per round, then issues that
// round's writes: up to 7 rounds and 21 writes before it returns to idle.
// A position left past twice the wrap size by a buffer_size change runs the
// remainder loop once. Writes hold while out_ready is low.
// Reset (rst_n low, async): config, control state and positions to defaults; no clearing pass.
// ----------------------------------------------------------------------------
// rgb_run_length_dither_expander
// Expands RGB run-length groups into dithered frame buffer writes.
// ----------------------------------------------------------------------------
module rgb_run_length_dither_expander
    import rlde_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input item channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [BYTE_WIDTH-1:0]      data_byte,
    // write result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ADDR_WIDTH-1:0]      write_address,
    output logic [BYTE_WIDTH-1:0]      write_value,
    output logic [CHANNEL_WIDTH-1:0]   channel,
    output logic                       last_write,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    rlde_cmd_t cmd;
    rlde_sts_t sts;

    // Configuration registers take a transaction every cycle; out-of-range
    // indexes drop silently.
    assign cfg_ready = 1'b1;

    // Sequencer: accepts one transaction at a time from idle, tracks the
    // three-byte group and walks rounds, writes and the remainder loop.
    rlde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: positions advance by three and wrap, the LFSR draws one
    // dither amount per round, the output register parts the result side.
    rlde_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .write_address (write_address),
        .write_value   (write_value),
        .channel       (channel),
        .last_write    (last_write)
    );

endmodule

FILE: test/tb_rgb_run_length_dither_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_run_length_dither_expander
// Drives compressed RGB bytes, restarts and register writes into the expander.
// Writes are checked against an in-bench model of unpacking, LFSR dither and
// position wrap, or a typed row's list. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_run_length_dither_expander;
    import rlde_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 12;
    // Covers the worst group; a position far past the wrap point adds the
    // remainder loop on top of that.
    localparam int SETTLE_CYCLES    = 64;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int PRESSURE_EVERY   = 25;
    localparam int MAX_REPORTS      = 10;
    localparam int LIMIT_NS         = 20_000_000;

    // Register indexes past the last one; the block must ignore them.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HIGH = 3'd7;

    localparam logic [BYTE_WIDTH-1:0] COLOUR_MASK = 8'hF8;
    localparam logic [BYTE_WIDTH-1:0] COUNT_MASK  = 8'h07;

    // One frame buffer write, in port order.
    typedef struct packed {
        logic [ADDR_WIDTH-1:0]    addr;
        logic [BYTE_WIDTH-1:0]    value;
        logic [CHANNEL_WIDTH-1:0] chan;
        logic                     last;
    } fb_write_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_RESTART,
        ROW_REG
    } row_kind_t;

    // One line of stimulus. When typed is set, the writes in w are the
    // expected result of this row instead of the model's prediction.
    typedef struct packed {
        row_kind_t                  kind;
        logic [BYTE_WIDTH-1:0]      byte_v;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_WIDTH-1:0]       reg_val;
        logic                       typed;
        logic [1:0]                 n_typed;
        fb_write_t [0:2]            w;
    } stim_row_t;

    localparam stim_row_t RESTART_ROW = '{ROW_RESTART, '0, '0, '0, 1'b0, 2'd0, '0};

    localparam int N_DIR = 37;

    // Directed part: corner values, restart mid-group, every register at
    // its extremes, and a shrink of the buffer that strands positions far
    // beyond the new wrap point.
    stim_row_t dir_rows [N_DIR] = '{
        // Zero colour with count one after reset: values read as zero,
        // written green, red, blue at the reset positions.
        '{ROW_BYTE,    8'h01, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h01, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h01, '0, '0, 1'b1, 2'd3,
          '{'{16'd1, 8'd0, CH_GREEN, 1'b0},
            '{16'd0, 8'd0, CH_RED,   1'b0},
            '{16'd2, 8'd0, CH_BLUE,  1'b1}}},
        // All counts zero: no writes.
        '{ROW_BYTE,    8'hF8, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hF8, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hF8, '0, '0, 1'b1, 2'd0, '0},
        // Full counts, top colour: seven rounds at the top of the value range.
        '{ROW_BYTE,    8'hFF, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hFF, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hFF, '0, '0, 1'b0, 2'd0, '0},
        // Restart drops a half-built group.
        '{ROW_BYTE,    8'h55, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_RESTART, 8'hFF, '0, '0, 1'b1, 2'd0, '0},
        '{ROW_BYTE,    8'h08, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hF1, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h86, '0, '0, 1'b0, 2'd0, '0},
        // Buffer below the minimum, a start past the wrap, zero seed.
        '{ROW_REG,     '0, CFG_BUFFER_SIZE, 16'd0,      1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_RED_START,   16'd2,      1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_GREEN_START, 16'd5,      1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_BLUE_START,  16'd1,      1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_DITHER_SEED, 16'd0,      1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_SPARE_LOW,   16'hFFFF,   1'b0, 2'd0, '0},
        '{ROW_RESTART, 8'h00, '0, '0, 1'b1, 2'd0, '0},
        '{ROW_BYTE,    8'h07, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h07, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h07, '0, '0, 1'b0, 2'd0, '0},
        // Largest buffer, starts at the top of the range.
        '{ROW_REG,     '0, CFG_BUFFER_SIZE, 16'hFFFF,   1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_RED_START,   16'd65534,  1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_GREEN_START, 16'd65533,  1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_BLUE_START,  16'd40000,  1'b0, 2'd0, '0},
        '{ROW_REG,     '0, CFG_DITHER_SEED, 16'hFFFF,   1'b0, 2'd0, '0},
        '{ROW_RESTART, 8'h5A, '0, '0, 1'b1, 2'd0, '0},
        '{ROW_BYTE,    8'hFA, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h0B, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hF4, '0, '0, 1'b0, 2'd0, '0},
        // Shrink without restart: blue sits far past twice the new size.
        '{ROW_REG,     '0, CFG_BUFFER_SIZE, 16'd7,      1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h13, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'h27, '0, '0, 1'b0, 2'd0, '0},
        '{ROW_BYTE,    8'hE5, '0, '0, 1'b0, 2'd0, '0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       mode;
    logic [BYTE_WIDTH-1:0]      data_byte;
    logic                       out_valid;
    logic                       out_ready;
    logic [ADDR_WIDTH-1:0]      write_address;
    logic [BYTE_WIDTH-1:0]      write_value;
    logic [CHANNEL_WIDTH-1:0]   channel;
    logic                       last_write;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    rgb_run_length_dither_expander u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_value   (write_value),
        .channel       (channel),
        .last_write    (last_write),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Writes predicted but not yet seen on the output, oldest first.
    fb_write_t   pending_writes [$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    // ------------------------------------------------------------------
    // Expander model state, starting from the reset values.
    // ------------------------------------------------------------------
    logic [CFG_WIDTH-1:0]   reg_buffer_size = BUFFER_SIZE_RESET;
    logic [CFG_WIDTH-1:0]   reg_red_start   = RED_START_RESET;
    logic [CFG_WIDTH-1:0]   reg_green_start = GREEN_START_RESET;
    logic [CFG_WIDTH-1:0]   reg_blue_start  = BLUE_START_RESET;
    logic [CFG_WIDTH-1:0]   reg_seed        = SEED_RESET;
    logic [GROUP_WIDTH-1:0] bytes_in_group  = GROUP_FIRST;
    logic [BYTE_WIDTH-1:0]  held_byte [2]   = '{8'd0, 8'd0};
    // Indexed by channel code: green, red, blue.
    logic [ADDR_WIDTH-1:0]  fb_pos [3]      = '{GREEN_START_RESET, RED_START_RESET,
                                                BLUE_START_RESET};
    logic [LFSR_WIDTH-1:0]  dither_state    = SEED_RESET;

    // Wrap point of the positions; sizes below three act as three.
    function automatic int unsigned wrap_len();
        int unsigned span;
        span = reg_buffer_size;
        if (span < 3) span = 3;
        return span;
    endfunction

    function automatic logic [ADDR_WIDTH-1:0] start_pos(input logic [CFG_WIDTH-1:0] v);
        return (v >= wrap_len()) ? '0 : v;
    endfunction

    task automatic apply_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        case (idx)
            CFG_BUFFER_SIZE: reg_buffer_size = val;
            CFG_RED_START:   reg_red_start   = val;
            CFG_GREEN_START: reg_green_start = val;
            CFG_BLUE_START:  reg_blue_start  = val;
            CFG_DITHER_SEED: reg_seed        = val;
            default: ;
        endcase
    endtask

    // Advance the model by one input and return the writes it causes.
    task automatic expand_item(input logic restart, input logic [BYTE_WIDTH-1:0] b,
                               output fb_write_t writes [$]);
        logic [BYTE_WIDTH-1:0] colour [3];
        int unsigned           left [3];
        int unsigned           rounds;
        int                    amount;
        int                    sum;
        fb_write_t             w;
        writes = {};
        if (restart) begin
            bytes_in_group   = GROUP_FIRST;
            fb_pos[CH_RED]   = start_pos(reg_red_start);
            fb_pos[CH_GREEN] = start_pos(reg_green_start);
            fb_pos[CH_BLUE]  = start_pos(reg_blue_start);
            dither_state     = (reg_seed != '0) ? reg_seed : LFSR_DEFAULT;
        end else if (bytes_in_group != GROUP_LAST) begin
            held_byte[bytes_in_group] = b;
            bytes_in_group = bytes_in_group + 1'b1;
        end else begin
            bytes_in_group   = GROUP_FIRST;
            // Group arrives red, green, blue.
            colour[CH_RED]   = held_byte[0] & COLOUR_MASK;
            left[CH_RED]     = held_byte[0] & COUNT_MASK;
            colour[CH_GREEN] = held_byte[1] & COLOUR_MASK;
            left[CH_GREEN]   = held_byte[1] & COUNT_MASK;
            colour[CH_BLUE]  = b & COLOUR_MASK;
            left[CH_BLUE]    = b & COUNT_MASK;
            rounds = left[0];
            if (left[1] > rounds) rounds = left[1];
            if (left[2] > rounds) rounds = left[2];
            for (int r = 0; r < rounds; r++) begin
                // Galois step, then one shared offset for the round.
                if (dither_state[0])
                    dither_state = (dither_state >> 1) ^ LFSR_TAPS;
                else
                    dither_state = dither_state >> 1;
                amount = int'(dither_state % 16'd15) - 7;
                // Channel codes run green, red, blue: the write order.
                for (int c = 0; c < 3; c++) begin
                    if (left[c] != 0) begin
                        left[c]--;
                        sum = int'(colour[c]) + amount;
                        if (sum < 0) sum = 0;
                        if (sum > 255) sum = 255;
                        w.addr  = fb_pos[c];
                        w.value = (colour[c] == '0) ? '0 : sum[BYTE_WIDTH-1:0];
                        w.chan  = CHANNEL_WIDTH'(c);
                        w.last  = (left[0] + left[1] + left[2] == 0);
                        writes.push_back(w);
                        fb_pos[c] = ADDR_WIDTH'((32'(fb_pos[c]) + 3) % wrap_len());
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver stalls and the output checker.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample between edges: the handshake at the next rising edge is fixed
    // by then, since every input changes only on the rising edge.
    always @(negedge clk) begin : check_writes
        fb_write_t got;
        fb_write_t want;
        if (rst_n && out_valid && out_ready) begin
            got = '{write_address, write_value, channel, last_write};
            if (pending_writes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected write addr %0d value %0d ch %0d last %0d",
                             $realtime, got.addr, got.value, got.chan, got.last);
            end else begin
                want = pending_writes.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: write mismatch: expected addr %0d value %0d ch %0d last %0d, got addr %0d value %0d ch %0d last %0d",
                                 $realtime, want.addr, want.value, want.chan, want.last,
                                 got.addr, got.value, got.chan, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks. Each is entered and left just after a rising edge.
    // ------------------------------------------------------------------

    // Present one input transaction, hold it until taken, then queue what
    // it should produce.
    task automatic send_item(input stim_row_t row);
        fb_write_t predicted [$];
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        mode      <= (row.kind == ROW_RESTART);
        data_byte <= row.byte_v;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        expand_item(row.kind == ROW_RESTART, row.byte_v, predicted);
        if (row.typed) begin
            for (int i = 0; i < row.n_typed; i++) pending_writes.push_back(row.w[i]);
        end else begin
            foreach (predicted[i]) pending_writes.push_back(predicted[i]);
        end
    endtask

    // Drop valid and hold off until every predicted write has come out.
    task automatic hold_for_writes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0) @(posedge clk);
    endtask

    // Register writes go in only once the block has gone quiet; the remainder
    // loop may still run after the last write, so give it the settle time too.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        hold_for_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_row(input stim_row_t row);
        if (row.kind == ROW_REG)
            write_reg(row.reg_idx, row.reg_val);
        else
            send_item(row);
    endtask

    // Starts mostly inside the current wrap, sometimes anywhere.
    function automatic logic [CFG_WIDTH-1:0] random_start();
        if ($urandom_range(3) == 0) return CFG_WIDTH'($urandom);
        return CFG_WIDTH'($urandom_range(0, wrap_len() - 1));
    endfunction

    task automatic randomize_regs();
        logic [CFG_WIDTH-1:0] size_v;
        case ($urandom_range(4))
            0:       size_v = CFG_WIDTH'($urandom_range(0, 2));
            1:       size_v = 16'd3;
            2:       size_v = CFG_WIDTH'($urandom_range(4, 64));
            3:       size_v = 16'hFFFF;
            default: size_v = CFG_WIDTH'($urandom);
        endcase
        write_reg(CFG_BUFFER_SIZE, size_v);
        write_reg(CFG_RED_START, random_start());
        write_reg(CFG_GREEN_START, random_start());
        write_reg(CFG_BLUE_START, random_start());
        write_reg(CFG_DITHER_SEED,
                  ($urandom_range(9) == 0) ? 16'd0 : CFG_WIDTH'($urandom));
        if ($urandom_range(1) == 1) write_reg(CFG_SPARE_HIGH, CFG_WIDTH'($urandom));
    endtask

    // Mostly data bytes with biased colours and counts; a few restarts
    // break groups apart.
    function automatic stim_row_t random_row();
        stim_row_t             r;
        logic [BYTE_WIDTH-1:0] colour;
        logic [BYTE_WIDTH-1:0] count;
        r = RESTART_ROW;
        r.byte_v = BYTE_WIDTH'($urandom);
        if ($urandom_range(99) < 4) return r;
        r.kind = ROW_BYTE;
        case ($urandom_range(7))
            0, 1:    colour = '0;
            2:       colour = COLOUR_MASK;
            3:       colour = 8'h08;
            default: colour = BYTE_WIDTH'($urandom) & COLOUR_MASK;
        endcase
        case ($urandom_range(9))
            0:       count = '0;
            1, 2:    count = COUNT_MASK;
            default: count = BYTE_WIDTH'($urandom_range(1, 6));
        endcase
        r.byte_v = colour | count;
        return r;
    endfunction

    task automatic run_random_phase(input int n_items);
        randomize_regs();
        send_item(RESTART_ROW);
        for (int i = 0; i < n_items; i++) begin
            // Let the output run dry now and then before the next byte.
            if (i % PRESSURE_EVERY == PRESSURE_EVERY - 1) hold_for_writes();
            send_item(random_row());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= 1'b0;
        data_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow receiver: writes back up while the sender runs ahead.
        send_idle_pct = 18;
        recv_idle_pct = 81;
        foreach (dir_rows[i]) run_row(dir_rows[i]);
        run_random_phase(RANDOM_PER_PHASE);

        // Slow sender: the block drains between bytes.
        send_idle_pct = 81;
        recv_idle_pct = 18;
        run_random_phase(RANDOM_PER_PHASE);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(RANDOM_PER_PHASE);

        // Drain, then watch a while for stray writes.
        hold_for_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatch_count += pending_writes.size();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard.
    initial begin
        #LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rlde_pkg.sv
rtl/core/rlde_datapath.sv
rtl/core/rlde_ctrl.sv
rtl/core/rgb_run_length_dither_expander.sv
test/tb_rgb_run_length_dither_expander.sv
